// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants, header layout and sequencer states of the allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ArenaBytesDef = 65536;
  localparam int unsigned AlignBytes    = 8;
  localparam int unsigned MinPayload    = 16;
  localparam int unsigned HdrBytes      = 8;
  localparam int unsigned SplitExtra    = MinPayload + HdrBytes;

  // header word: size [15:0], previous size [31:16], free [32], previous free [33]
  // link word: next [15:0], prev [31:16], bit 15 of each link marks it valid
  localparam logic [63:0] MaskSize     = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] MaskPrevSize = 64'h0000_0000_FFFF_0000;
  localparam logic [63:0] MaskFree     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MaskPrevFree = 64'h0000_0002_0000_0000;
  localparam logic [63:0] MaskNext     = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] MaskPrev     = 64'h0000_0000_FFFF_0000;
  localparam int unsigned FreeBit      = 32;
  localparam int unsigned PrevFreeBit  = 33;
  localparam int unsigned LinkValidBit = 15;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_HDR,
    S_A_LINK,
    S_A_FIT,
    S_A_WHOLE_F,
    S_A_SPLIT_S,
    S_A_SPLIT_F,
    S_A_SPLIT_PUSH,
    S_F_WALK,
    S_F_STEP,
    S_F_HDR,
    S_F_PREV,
    S_F_AFTER_P,
    S_F_NEXT,
    S_F_SET_H,
    S_F_SET_F,
    S_F_PUSH,
    S_U_RD,
    S_U_NEXT,
    S_U_PREV,
    S_P_WR,
    S_P_END,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE_OK,
    S_FAIL
  } state_e;

endpackage

// ===== src/first_fit_boundary_tag_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// first-fit heap allocator with boundary tags over a word-organized arena
// ----------------------------------------------------------------------------
//  channel   direction  ports                                        transfer
//  command   in         start_i, busy_o, command_i, request_bytes_i, start_i & !busy_o
//                       free_address_i
//  result    out        done_o, address_o, ok_o                      done_o
//
// the sequencer makes at most one arena access at a time; an allocate walks
// the free list entry by entry, then accepts, unlinks, splits, pushes and
// gives the result; a free walks the blocks from the arena start to the
// freed header, then accepts, does both merges, pushes and gives the
// result
// reset gives one free block and the end sentinel at once, no clearing pass
// the result shows for one cycle on done_o; the receiver cannot stall it
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator #(
  parameter int unsigned ARENA_BYTES = ffba_pkg::ArenaBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] free_address_i,
  output logic        done_o,
  output logic [15:0] address_o,
  output logic        ok_o
);

  localparam int unsigned AW = $clog2(ARENA_BYTES / ffba_pkg::AlignBytes);

  // arena memory port
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [63:0]   rdata, wdata;

  // sequencer: list walk, chain walk, unlink, split, merge and push
  ffba_seq #(
    .ARENA_BYTES(ARENA_BYTES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .command_i      (command_i),
    .request_bytes_i(request_bytes_i),
    .free_address_i (free_address_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .address_o      (address_o),
    .ok_o           (ok_o),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata)
  );

  // header and link words of the arena
  ffba_mem #(
    .ARENA_BYTES(ARENA_BYTES)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata)
  );

endmodule

// ===== src/ffba_mem.sv =====
// ----------------------------------------------------------------------------
// ffba_mem
// arena word memory, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module ffba_mem #(
  parameter int unsigned ARENA_BYTES = ffba_pkg::ArenaBytesDef
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           re_i,
  input  logic [$clog2(ARENA_BYTES/ffba_pkg::AlignBytes)-1:0] raddr_i,
  output logic [63:0]                                    rdata_o,
  input  logic                                           we_i,
  input  logic [$clog2(ARENA_BYTES/ffba_pkg::AlignBytes)-1:0] waddr_i,
  input  logic [63:0]                                    wdata_i
);

  localparam int unsigned Words = ARENA_BYTES / ffba_pkg::AlignBytes;
  localparam int unsigned AW    = $clog2(Words);
  localparam logic [AW-1:0] LastIdx = AW'(Words - 1);
  localparam logic [15:0] InitSize  = 16'(ARENA_BYTES - 2 * ffba_pkg::HdrBytes);
  localparam logic [63:0] InitFirst = {30'd0, 1'b0, 1'b1, 16'd0, InitSize};
  localparam logic [63:0] InitLast  = {30'd0, 1'b1, 1'b0, InitSize, 16'd0};

  logic [63:0] mem [Words];
  logic [63:0] rd_q;
  // words that carry a reset value read as that value until first written
  logic w0_q, w1_q, wl_q;
  logic s0_q, s1_q, sl_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q <= 1'b0;
      w1_q <= 1'b0;
      wl_q <= 1'b0;
      s0_q <= 1'b0;
      s1_q <= 1'b0;
      sl_q <= 1'b0;
    end else begin
      if (we_i && waddr_i == '0) w0_q <= 1'b1;
      if (we_i && waddr_i == AW'(1)) w1_q <= 1'b1;
      if (we_i && waddr_i == LastIdx) wl_q <= 1'b1;
      if (re_i) begin
        s0_q <= (raddr_i == '0) && !w0_q;
        s1_q <= (raddr_i == AW'(1)) && !w1_q;
        sl_q <= (raddr_i == LastIdx) && !wl_q;
      end
    end
  end

  always_comb begin
    rdata_o = rd_q;
    if (s0_q) rdata_o = InitFirst;
    if (s1_q) rdata_o = '0;
    if (sl_q) rdata_o = InitLast;
  end

endmodule

// ===== src/ffba_seq.sv =====
// ----------------------------------------------------------------------------
// ffba_seq
// sequencer that walks and edits the arena one memory access at a time
// ----------------------------------------------------------------------------
module ffba_seq #(
  parameter int unsigned ARENA_BYTES = ffba_pkg::ArenaBytesDef
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic                                           command_i,
  input  logic [15:0]                                    request_bytes_i,
  input  logic [15:0]                                    free_address_i,
  output logic                                           busy_o,
  output logic                                           done_o,
  output logic [15:0]                                    address_o,
  output logic                                           ok_o,
  output logic                                           re_o,
  output logic [$clog2(ARENA_BYTES/ffba_pkg::AlignBytes)-1:0] raddr_o,
  input  logic [63:0]                                    rdata_i,
  output logic                                           we_o,
  output logic [$clog2(ARENA_BYTES/ffba_pkg::AlignBytes)-1:0] waddr_o,
  output logic [63:0]                                    wdata_o
);

  localparam int unsigned Words = ARENA_BYTES / ffba_pkg::AlignBytes;
  localparam int unsigned AW    = $clog2(Words);
  localparam logic [16:0] LastW = 17'(Words - 1);
  localparam logic [12:0] MaxHdr = 13'(Words - 2);

  ffba_pkg::state_e state_q, state_d, ret_q, ret_d, sret_q, sret_d;
  logic [AW-1:0] head_q, head_d;
  logic          hv_q, hv_d;
  logic [16:0]   size_q, size_d;
  logic [AW-1:0] b_q, b_d, s_q, s_d, h_q, h_d, a_q, a_d, cur_q, cur_d, ux_q, ux_d;
  logic [15:0]   bsz_q, bsz_d, rest_q, rest_d, hsz_q, hsz_d, n_q, n_d, p_q, p_d;
  logic [15:0]   res_q, res_d;
  logic [AW-1:0] ma_q, ma_d;
  logic [63:0]   mm_q, mm_d, mv_q, mv_d;

  logic [16:0] req_max, fstep;
  logic [12:0] hw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
      ret_q   <= ffba_pkg::S_IDLE;
      sret_q  <= ffba_pkg::S_IDLE;
      head_q  <= '0;
      hv_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sret_q  <= sret_d;
      head_q  <= head_d;
      hv_q    <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    b_q    <= b_d;
    s_q    <= s_d;
    h_q    <= h_d;
    a_q    <= a_d;
    cur_q  <= cur_d;
    ux_q   <= ux_d;
    bsz_q  <= bsz_d;
    rest_q <= rest_d;
    hsz_q  <= hsz_d;
    n_q    <= n_d;
    p_q    <= p_d;
    res_q  <= res_d;
    ma_q   <= ma_d;
    mm_q   <= mm_d;
    mv_q   <= mv_d;
  end

  assign req_max = (request_bytes_i < 16'(ffba_pkg::MinPayload)) ?
                   17'(ffba_pkg::MinPayload) : {1'b0, request_bytes_i};
  assign hw      = free_address_i[15:3] - 13'd1;
  assign fstep   = 17'(cur_q) + 17'd1 + 17'(rdata_i[15:3]);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    sret_d  = sret_q;
    head_d  = head_q;
    hv_d    = hv_q;
    size_d  = size_q;
    b_d     = b_q;
    s_d     = s_q;
    h_d     = h_q;
    a_d     = a_q;
    cur_d   = cur_q;
    ux_d    = ux_q;
    bsz_d   = bsz_q;
    rest_d  = rest_q;
    hsz_d   = hsz_q;
    n_d     = n_q;
    p_d     = p_q;
    res_d   = res_q;
    ma_d    = ma_q;
    mm_d    = mm_q;
    mv_d    = mv_q;
    re_o    = 1'b0;
    raddr_o = '0;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = '0;
    busy_o  = (state_q != ffba_pkg::S_IDLE);
    done_o  = 1'b0;
    ok_o    = 1'b0;
    address_o = '0;

    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        if (start_i) begin
          if (!command_i) begin
            size_d = (req_max + 17'd7) & ~17'd7;
            if (request_bytes_i == '0 || !hv_q) begin
              state_d = ffba_pkg::S_FAIL;
            end else begin
              b_d     = head_q;
              re_o    = 1'b1;
              raddr_o = head_q;
              state_d = ffba_pkg::S_A_HDR;
            end
          end else begin
            cur_d = '0;
            h_d   = AW'(hw);
            if (free_address_i == '0 || free_address_i[2:0] != 3'd0 || hw > MaxHdr) begin
              state_d = ffba_pkg::S_FAIL;
            end else begin
              state_d = ffba_pkg::S_F_WALK;
            end
          end
        end
      end

      // first-fit walk of the free list
      ffba_pkg::S_A_HDR: begin
        bsz_d = rdata_i[15:0];
        if ({1'b0, rdata_i[15:0]} >= size_q) begin
          ux_d    = b_q;
          sret_d  = ffba_pkg::S_A_FIT;
          state_d = ffba_pkg::S_U_RD;
        end else begin
          re_o    = 1'b1;
          raddr_o = b_q + AW'(1);
          state_d = ffba_pkg::S_A_LINK;
        end
      end
      ffba_pkg::S_A_LINK: begin
        if (!rdata_i[ffba_pkg::LinkValidBit]) begin
          state_d = ffba_pkg::S_FAIL;
        end else begin
          b_d     = rdata_i[AW-1:0];
          re_o    = 1'b1;
          raddr_o = rdata_i[AW-1:0];
          state_d = ffba_pkg::S_A_HDR;
        end
      end
      ffba_pkg::S_A_FIT: begin
        ma_d    = b_q;
        state_d = ffba_pkg::S_RMW_RD;
        if ({2'b0, bsz_q} >= {1'b0, size_q} + 18'(ffba_pkg::SplitExtra)) begin
          rest_d = bsz_q - 16'(size_q) - 16'(ffba_pkg::HdrBytes);
          mm_d   = ffba_pkg::MaskSize;
          mv_d   = {48'd0, bsz_q - 16'(size_q) - 16'(ffba_pkg::HdrBytes)};
          ret_d  = ffba_pkg::S_A_SPLIT_S;
        end else begin
          mm_d  = ffba_pkg::MaskFree;
          mv_d  = '0;
          ret_d = ffba_pkg::S_A_WHOLE_F;
        end
      end
      ffba_pkg::S_A_WHOLE_F: begin
        ma_d    = AW'(17'(b_q) + 17'd1 + 17'(bsz_q[15:3]));
        mm_d    = ffba_pkg::MaskPrevFree;
        mv_d    = '0;
        res_d   = 16'({17'(b_q) + 17'd1, 3'b000});
        ret_d   = ffba_pkg::S_DONE_OK;
        state_d = ffba_pkg::S_RMW_RD;
      end
      ffba_pkg::S_A_SPLIT_S: begin
        // the tail block gets a whole new header
        s_d     = AW'(17'(b_q) + 17'd1 + 17'(rest_q[15:3]));
        we_o    = 1'b1;
        waddr_o = AW'(17'(b_q) + 17'd1 + 17'(rest_q[15:3]));
        wdata_o = {30'd0, 1'b1, 1'b0, rest_q, 16'(size_q)};
        state_d = ffba_pkg::S_A_SPLIT_F;
      end
      ffba_pkg::S_A_SPLIT_F: begin
        ma_d    = AW'(17'(s_q) + 17'd1 + {3'd0, size_q[16:3]});
        mm_d    = ffba_pkg::MaskPrevSize | ffba_pkg::MaskPrevFree;
        mv_d    = {32'd0, 16'(size_q), 16'd0};
        ret_d   = ffba_pkg::S_A_SPLIT_PUSH;
        state_d = ffba_pkg::S_RMW_RD;
      end
      ffba_pkg::S_A_SPLIT_PUSH: begin
        ux_d    = b_q;
        sret_d  = ffba_pkg::S_DONE_OK;
        res_d   = 16'({17'(s_q) + 17'd1, 3'b000});
        state_d = ffba_pkg::S_P_WR;
      end

      // free: walk the block chain to validate the header
      ffba_pkg::S_F_WALK: begin
        re_o = 1'b1;
        if (cur_q == h_q) begin
          raddr_o = h_q;
          state_d = ffba_pkg::S_F_HDR;
        end else begin
          raddr_o = cur_q;
          state_d = ffba_pkg::S_F_STEP;
        end
      end
      ffba_pkg::S_F_STEP: begin
        if (fstep >= LastW) begin
          state_d = ffba_pkg::S_FAIL;
        end else begin
          cur_d   = AW'(fstep);
          state_d = ffba_pkg::S_F_WALK;
        end
      end
      ffba_pkg::S_F_HDR: begin
        hsz_d = rdata_i[15:0];
        a_d   = AW'(17'(h_q) + 17'd1 + 17'(rdata_i[15:3]));
        re_o  = 1'b1;
        if (rdata_i[ffba_pkg::FreeBit]) begin
          re_o    = 1'b0;
          state_d = ffba_pkg::S_FAIL;
        end else if (rdata_i[ffba_pkg::PrevFreeBit]) begin
          ux_d    = AW'(17'(h_q) - 17'd1 - 17'(rdata_i[31:19]));
          raddr_o = AW'(17'(h_q) - 17'd1 - 17'(rdata_i[31:19]));
          state_d = ffba_pkg::S_F_PREV;
        end else begin
          raddr_o = AW'(17'(h_q) + 17'd1 + 17'(rdata_i[15:3]));
          state_d = ffba_pkg::S_F_NEXT;
        end
      end
      ffba_pkg::S_F_PREV: begin
        hsz_d   = rdata_i[15:0] + hsz_q + 16'(ffba_pkg::HdrBytes);
        h_d     = ux_q;
        sret_d  = ffba_pkg::S_F_AFTER_P;
        state_d = ffba_pkg::S_U_RD;
      end
      ffba_pkg::S_F_AFTER_P: begin
        re_o    = 1'b1;
        raddr_o = a_q;
        state_d = ffba_pkg::S_F_NEXT;
      end
      ffba_pkg::S_F_NEXT: begin
        if (rdata_i[ffba_pkg::FreeBit]) begin
          hsz_d   = rdata_i[15:0] + hsz_q + 16'(ffba_pkg::HdrBytes);
          ux_d    = a_q;
          sret_d  = ffba_pkg::S_F_SET_H;
          state_d = ffba_pkg::S_U_RD;
        end else begin
          state_d = ffba_pkg::S_F_SET_H;
        end
      end
      ffba_pkg::S_F_SET_H: begin
        ma_d    = h_q;
        mm_d    = ffba_pkg::MaskSize | ffba_pkg::MaskFree;
        mv_d    = {31'd0, 1'b1, 16'd0, hsz_q};
        ret_d   = ffba_pkg::S_F_SET_F;
        state_d = ffba_pkg::S_RMW_RD;
      end
      ffba_pkg::S_F_SET_F: begin
        ma_d    = AW'(17'(h_q) + 17'd1 + 17'(hsz_q[15:3]));
        mm_d    = ffba_pkg::MaskPrevSize | ffba_pkg::MaskPrevFree;
        mv_d    = {30'd0, 1'b1, 1'b0, hsz_q, 16'd0};
        ret_d   = ffba_pkg::S_F_PUSH;
        state_d = ffba_pkg::S_RMW_RD;
      end
      ffba_pkg::S_F_PUSH: begin
        ux_d    = h_q;
        sret_d  = ffba_pkg::S_DONE_OK;
        res_d   = '0;
        state_d = ffba_pkg::S_P_WR;
      end

      // unlink block ux from the free list
      ffba_pkg::S_U_RD: begin
        re_o    = 1'b1;
        raddr_o = ux_q + AW'(1);
        state_d = ffba_pkg::S_U_NEXT;
      end
      ffba_pkg::S_U_NEXT: begin
        n_d = rdata_i[15:0];
        p_d = rdata_i[31:16];
        if (rdata_i[ffba_pkg::LinkValidBit]) begin
          ma_d    = rdata_i[AW-1:0] + AW'(1);
          mm_d    = ffba_pkg::MaskPrev;
          mv_d    = {32'd0, rdata_i[31:16], 16'd0};
          ret_d   = ffba_pkg::S_U_PREV;
          state_d = ffba_pkg::S_RMW_RD;
        end else begin
          state_d = ffba_pkg::S_U_PREV;
        end
      end
      ffba_pkg::S_U_PREV: begin
        if (p_q[ffba_pkg::LinkValidBit]) begin
          ma_d    = p_q[AW-1:0] + AW'(1);
          mm_d    = ffba_pkg::MaskNext;
          mv_d    = {48'd0, n_q};
          ret_d   = sret_q;
          state_d = ffba_pkg::S_RMW_RD;
        end else begin
          head_d  = n_q[AW-1:0];
          hv_d    = n_q[ffba_pkg::LinkValidBit];
          state_d = sret_q;
        end
      end

      // push block ux onto the list head
      ffba_pkg::S_P_WR: begin
        we_o    = 1'b1;
        waddr_o = ux_q + AW'(1);
        wdata_o = {48'd0, hv_q, (15 - AW)'(0), head_q};
        if (hv_q) begin
          ma_d    = head_q + AW'(1);
          mm_d    = ffba_pkg::MaskPrev;
          mv_d    = {32'd0, 1'b1, (15 - AW)'(0), ux_q, 16'd0};
          ret_d   = ffba_pkg::S_P_END;
          state_d = ffba_pkg::S_RMW_RD;
        end else begin
          state_d = ffba_pkg::S_P_END;
        end
      end
      ffba_pkg::S_P_END: begin
        head_d  = ux_q;
        hv_d    = 1'b1;
        state_d = sret_q;
      end

      // read-modify-write of one word
      ffba_pkg::S_RMW_RD: begin
        re_o    = 1'b1;
        raddr_o = ma_q;
        state_d = ffba_pkg::S_RMW_WR;
      end
      ffba_pkg::S_RMW_WR: begin
        we_o    = 1'b1;
        waddr_o = ma_q;
        wdata_o = (rdata_i & ~mm_q) | (mv_q & mm_q);
        state_d = ret_q;
      end

      ffba_pkg::S_DONE_OK: begin
        done_o    = 1'b1;
        ok_o      = 1'b1;
        address_o = res_q;
        state_d   = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_FAIL: begin
        done_o  = 1'b1;
        state_d = ffba_pkg::S_IDLE;
      end
      default: begin
        state_d = ffba_pkg::S_IDLE;
      end
    endcase
  end

endmodule
